@@ hdl/jdg_pkg.sv @@
// ----------------------------------------------------------------------------
// jdg_pkg
// Shared widths, range limits, stage map and month table for the Julian day
// to Gregorian date converter.
// ----------------------------------------------------------------------------
package jdg_pkg;

  localparam int DAY_W    = 23;
  localparam int FRAC_W   = 16;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int MDAY_W   = 5;

  localparam int X1_W     = 24;
  localparam int ALF_W    = 7;
  localparam int B_W      = 23;
  localparam int X2_W     = 27;
  localparam int C_W      = 14;
  localparam int BD_W     = 9;
  localparam int X3_W     = 23;
  localparam int E_W      = 4;

  localparam logic [DAY_W-1:0] DAY_MIN = 23'd1867217;
  localparam logic [DAY_W-1:0] DAY_MAX = 23'd5373484;

  localparam int ALF_DIV  = 146097;
  localparam int C_DIV    = 7305;
  localparam int E_DIV    = 306001;

  localparam int ST_IN    = 0;
  localparam int ST_DIV1  = 1;
  localparam int ST_B     = 4;
  localparam int ST_X2    = 5;
  localparam int ST_DIV2  = 6;
  localparam int ST_BD    = 9;
  localparam int ST_X3    = 10;
  localparam int ST_DIV3  = 11;
  localparam int ST_OUT   = 14;
  localparam int NUM_STAGES = 15;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // floor(30.6001 * e)
  function automatic logic [BD_W-1:0] month_days(input logic [E_W-1:0] e);
    logic [BD_W-1:0] r;
    unique case (e)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/jdg_cdiv.sv @@
// ----------------------------------------------------------------------------
// jdg_cdiv
// Three-stage floor division by a constant: reciprocal multiply, remainder
// by back-multiply, one-step correction.
// ----------------------------------------------------------------------------
module jdg_cdiv #(
  parameter int N  = 24,
  parameter int D  = 146097,
  parameter int QW = 7
) (
  input  logic          clk_i,
  input  logic [2:0]    en_i,
  input  logic [N-1:0]  x_i,
  output logic [QW-1:0] q_o
);

  localparam longint unsigned RECIP = (64'd1 << N) / D;
  localparam int RW = $clog2(2 * D);
  localparam logic [N-1:0]  RECIP_W = N'(RECIP);
  localparam logic [N-1:0]  D_N     = N'(D);
  localparam logic [RW-1:0] D_R     = RW'(D);

  logic [N-1:0]   x_q;
  logic [2*N-1:0] prod_d, prod_q;
  logic [N-1:0]   q0_full, qd;
  logic [QW-1:0]  q0_q;
  logic [RW-1:0]  r_d, r_q;
  logic [QW-1:0]  q_d;

  assign prod_d  = (2*N)'(x_i) * (2*N)'(RECIP_W);
  assign q0_full = prod_q[2*N-1:N];
  assign qd      = q0_full * D_N;
  assign r_d     = RW'(x_q - qd);
  assign q_d     = q0_q + QW'(r_q >= D_R);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q    <= x_i;
      prod_q <= prod_d;
    end
    if (en_i[1]) begin
      q0_q <= q0_full[QW-1:0];
      r_q  <= r_d;
    end
    if (en_i[2]) begin
      q_o <= q_d;
    end
  end

endmodule

@@ hdl/jdg_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// jdg_pipe_ctrl
// Stage valid bits and per-stage load enables; a stage loads when it is
// empty or the stage after it moves.
// ----------------------------------------------------------------------------
module jdg_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jdg_pkg::stage_en_t en_o
);
  import jdg_pkg::*;

  stage_en_t valid_q, valid_d;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign en_o[k] = out_ready_i || !(&valid_q[NUM_STAGES-1:k]);
  end

  always_comb begin
    valid_d[0] = en_o[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = en_o[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en_o[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

`ifndef SYNTHESIS
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> &valid_q)
    else $error("input stalled with a bubble in the pipeline");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted item did not enter the first stage");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped under stall");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ready_i && valid_q[NUM_STAGES-1] && valid_q[NUM_STAGES-2]
    |=> valid_q[NUM_STAGES-2])
    else $error("stalled stage lost its item");
`endif

endmodule

@@ hdl/julian_day_to_gregorian.sv @@
// ----------------------------------------------------------------------------
// julian_day_to_gregorian
// Julian day number to proleptic Gregorian year, month and day of month.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the output is stalled with
// every stage full. Its pipeline holds the three constant divisions of the
// Meeus method (by 146097, 7305 and 306001), each a three-stage unit of
// reciprocal multiply, back-multiply and correction, the clamp, the stages
// between the divisions, the year and month sums and the output register.
// Day numbers outside 1867217 to 5373484 set range_error_o and are converted
// as the nearest end of that range. Backpressure holds each stage that cannot
// advance while bubbles ahead of it still fill.
// ----------------------------------------------------------------------------
module julian_day_to_gregorian #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [jdg_pkg::DAY_W-1:0]     day_number_i,
  input  logic [jdg_pkg::FRAC_W-1:0]    day_fraction_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [jdg_pkg::YEAR_W-1:0]    year_o,
  output logic [jdg_pkg::MONTH_W-1:0]   month_o,
  output logic [jdg_pkg::MDAY_W-1:0]    day_of_month_o,
  output logic [jdg_pkg::FRAC_W-1:0]    fraction_out_o,
  output logic                          range_error_o
);
  import jdg_pkg::*;

  localparam int FRAC_KEPT = (FRACTION_BITS > FRAC_W) ? FRAC_W : FRACTION_BITS;
  localparam logic [FRAC_W-1:0] FRAC_MASK = FRAC_W'((33'd1 << FRAC_KEPT) - 33'd1);

  stage_en_t en;

  logic [FRAC_W-1:0] frac_q [NUM_STAGES-1];
  logic              err_q  [NUM_STAGES-1];
  logic [DAY_W-1:0]  z_q    [ST_B];
  logic [X1_W-1:0]   x1_q;
  logic [B_W-1:0]    b_q    [ST_B:ST_BD-1];
  logic [X2_W-1:0]   x2_q;
  logic [C_W-1:0]    c_q    [ST_BD:ST_OUT-1];
  logic [BD_W-1:0]   bd_q   [ST_BD:ST_OUT-1];
  logic [X3_W-1:0]   x3_q;

  logic [ALF_W-1:0]  alf;
  logic [C_W-1:0]    c_div;
  logic [E_W-1:0]    e_div;

  logic [DAY_W-1:0]   z_d;
  logic               err_d;
  logic [X1_W-1:0]    x1_d;
  logic [B_W-1:0]     b_d;
  logic [X2_W-1:0]    x2_d;
  logic [BD_W-1:0]    bd_d;
  logic [X3_W-1:0]    x3_d;
  logic [MONTH_W-1:0] month_d;
  logic [YEAR_W-1:0]  year_d;
  logic [MDAY_W-1:0]  mday_d;

  jdg_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .en_o        (en)
  );

  // clamp to supported range
  always_comb begin
    z_d   = day_number_i;
    err_d = 1'b0;
    if (day_number_i < DAY_MIN) begin
      z_d   = DAY_MIN;
      err_d = 1'b1;
    end else if (day_number_i > DAY_MAX) begin
      z_d   = DAY_MAX;
      err_d = 1'b1;
    end
  end

  assign x1_d = X1_W'({2'b00, z_d, 2'b00} - 27'd7468865);

  jdg_cdiv #(.N(X1_W), .D(ALF_DIV), .QW(ALF_W)) u_div_alf (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV1+2:ST_DIV1]),
    .x_i   (x1_q),
    .q_o   (alf)
  );

  assign b_d = B_W'(z_q[ST_B-1]) + B_W'(1525) + B_W'(alf) - B_W'(alf >> 2);
  assign x2_d = X2_W'(b_q[ST_B]) * X2_W'(20) - X2_W'(2442);

  jdg_cdiv #(.N(X2_W), .D(C_DIV), .QW(C_W)) u_div_c (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV2+2:ST_DIV2]),
    .x_i   (x2_q),
    .q_o   (c_div)
  );

  assign bd_d = BD_W'(b_q[ST_BD-1]
                - (B_W'(c_div) * B_W'(365) + B_W'(c_div >> 2)));
  assign x3_d = X3_W'(bd_q[ST_BD]) * X3_W'(10000);

  jdg_cdiv #(.N(X3_W), .D(E_DIV), .QW(E_W)) u_div_e (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV3+2:ST_DIV3]),
    .x_i   (x3_q),
    .q_o   (e_div)
  );

  assign mday_d  = MDAY_W'(bd_q[ST_OUT-1] - month_days(e_div));
  assign month_d = (e_div > 4'd13) ? e_div - 4'd13 : e_div - 4'd1;
  assign year_d  = (month_d > 4'd2) ? c_q[ST_OUT-1] - YEAR_W'(4716)
                                    : c_q[ST_OUT-1] - YEAR_W'(4715);

  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      frac_q[ST_IN] <= day_fraction_i & FRAC_MASK;
      err_q[ST_IN]  <= err_d;
      z_q[ST_IN]    <= z_d;
      x1_q          <= x1_d;
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (en[k]) begin
        frac_q[k] <= frac_q[k-1];
        err_q[k]  <= err_q[k-1];
      end
    end
    for (int k = 1; k < ST_B; k++) begin
      if (en[k]) z_q[k] <= z_q[k-1];
    end
    if (en[ST_B]) b_q[ST_B] <= b_d;
    for (int k = ST_B + 1; k < ST_BD; k++) begin
      if (en[k]) b_q[k] <= b_q[k-1];
    end
    if (en[ST_X2]) x2_q <= x2_d;
    if (en[ST_BD]) begin
      c_q[ST_BD]  <= c_div;
      bd_q[ST_BD] <= bd_d;
    end
    for (int k = ST_BD + 1; k < ST_OUT; k++) begin
      if (en[k]) begin
        c_q[k]  <= c_q[k-1];
        bd_q[k] <= bd_q[k-1];
      end
    end
    if (en[ST_X3]) x3_q <= x3_d;
    if (en[ST_OUT]) begin
      year_o         <= year_d;
      month_o        <= month_d;
      day_of_month_o <= mday_d;
      fraction_out_o <= frac_q[ST_OUT-1];
      range_error_o  <= err_q[ST_OUT-1];
    end
  end

endmodule
